// File: hdl/twre_pkg.sv
package twre_pkg;

   // Field widths of the transaction payloads and the configuration registers.
   localparam int CMD_W       = 2;
   localparam int INDEX_W     = 8;
   localparam int COORD_W     = 16;
   localparam int DEMAND_W    = 16;
   localparam int TIME_W      = 20;
   localparam int COUNT_W     = 9;
   localparam int FAIL_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Fixed-point widths: times and cost are Q32.16, loads carry one spare bit.
   localparam int FRAC_W   = 16;
   localparam int CLOCK_W  = 48;
   localparam int ARRIVE_W = CLOCK_W + 1;
   localparam int LOAD_W   = DEMAND_W + 1;
   localparam int SQ_W     = 2 * COORD_W;
   localparam int RAD_SHIFT = 24;
   localparam int RAD_W    = SQ_W + 1 + RAD_SHIFT;
   localparam int ROOT_W   = (RAD_W + 1) / 2;

   // Command queue between the front end and the execution unit.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_VISIT  = 2'd1,
      CMD_FINISH = 2'd2
   } twre_cmd_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_VISIT,
      OP_FINISH
   } twre_op_type;

   typedef enum logic [FAIL_W-1:0] {
      FAIL_NONE     = 2'd0,
      FAIL_INDEX    = 2'd1,
      FAIL_CAPACITY = 2'd2,
      FAIL_LATE     = 2'd3
   } twre_fail_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEPOT_X  = 2'd0,
      CSR_DEPOT_Y  = 2'd1,
      CSR_CAPACITY = 2'd2,
      CSR_COUNT    = 2'd3
   } twre_csr_type;

   // One customer table entry as it is kept in memory.
   typedef struct packed {
      logic [TIME_W-1:0]   dwell_time;
      logic [TIME_W-1:0]   due_time;
      logic [TIME_W-1:0]   open_time;
      logic [DEMAND_W-1:0] demand;
      logic [COORD_W-1:0]  pos_y;
      logic [COORD_W-1:0]  pos_x;
   } twre_entry_type;

   localparam int ENTRY_W = $bits(twre_entry_type);

   // One classified transaction waiting for the execution unit.
   typedef struct packed {
      twre_op_type          op;
      logic                 bad_index;
      logic [INDEX_W-1:0]   customer_index;
      twre_entry_type       entry;
   } twre_job_type;

   // Configuration register contents.
   typedef struct packed {
      logic [COORD_W-1:0]  depot_x;
      logic [COORD_W-1:0]  depot_y;
      logic [DEMAND_W-1:0] vehicle_capacity;
      logic [COUNT_W-1:0]  customer_count;
   } twre_cfg_type;

endpackage

// File: hdl/twre_if.sv
interface twre_req_if import twre_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [INDEX_W-1:0]  customer_index;
   logic [COORD_W-1:0]  pos_x;
   logic [COORD_W-1:0]  pos_y;
   logic [DEMAND_W-1:0] demand;
   logic [TIME_W-1:0]   open_time;
   logic [TIME_W-1:0]   due_time;
   logic [TIME_W-1:0]   dwell_time;

   modport source (
      output valid, command, customer_index, pos_x, pos_y, demand,
             open_time, due_time, dwell_time,
      input  ready
   );
   modport sink (
      input  valid, command, customer_index, pos_x, pos_y, demand,
             open_time, due_time, dwell_time,
      output ready
   );
endinterface

interface twre_rsp_if import twre_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CLOCK_W-1:0] route_cost;
   logic               feasible;
   logic [FAIL_W-1:0]  fail_reason;

   modport source (
      output valid, route_cost, feasible, fail_reason,
      input  ready
   );
   modport sink (
      input  valid, route_cost, feasible, fail_reason,
      output ready
   );
endinterface

// File: hdl/twre_ram.sv
module twre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/twre_queue.sv
module twre_queue import twre_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  twre_job_type push_job,
   output logic         full,
   input  logic         pop,
   output logic         valid,
   output twre_job_type head_job
);

   twre_job_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign full     = (32'(count_ff) == QUEUE_DEPTH);
   assign valid    = (count_ff != '0);
   assign head_job = slot_ff[rd_ptr_ff];

   // The front end never pushes into a full queue, the back end never pops an empty one.
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> (32'(count_ff) < QUEUE_DEPTH))
      else $error("command queue written while full");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("command queue read while empty");

endmodule

// File: hdl/twre_front.sv
module twre_front import twre_pkg::*; #(
   parameter int MAX_CUSTOMERS = 256
) (
   twre_req_if.sink       req_chan,
   input  twre_cfg_type   cfg,
   output logic           push,
   output twre_job_type   push_job,
   input  logic           full
);

   logic in_table;
   logic accept;

   // A transaction is taken whenever the queue has room.
   assign req_chan.ready = !full;
   assign accept         = req_chan.valid && !full;
   assign in_table       = (32'(req_chan.customer_index) < MAX_CUSTOMERS);

   // Classify the command; loads beyond the table and unknown commands are dropped.
   always_comb begin
      push_job.op                 = OP_LOAD;
      push_job.bad_index          = !in_table ||
         ({1'b0, req_chan.customer_index} >= cfg.customer_count);
      push_job.customer_index     = req_chan.customer_index;
      push_job.entry.pos_x        = req_chan.pos_x;
      push_job.entry.pos_y        = req_chan.pos_y;
      push_job.entry.demand       = req_chan.demand;
      push_job.entry.open_time    = req_chan.open_time;
      push_job.entry.due_time     = req_chan.due_time;
      push_job.entry.dwell_time   = req_chan.dwell_time;
      push = 1'b0;
      case (req_chan.command)
         CMD_LOAD: begin
            push_job.op = OP_LOAD;
            push        = accept && in_table;
         end
         CMD_VISIT: begin
            push_job.op = OP_VISIT;
            push        = accept;
         end
         CMD_FINISH: begin
            push_job.op = OP_FINISH;
            push        = accept;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

// File: hdl/twre_sqrt.sv
module twre_sqrt import twre_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0] rem_ff, rem_in;
   logic [RAD_W-1:0] root_ff, root_in;
   logic [RAD_W-1:0] bit_ff, bit_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [RAD_W-1:0] trial;

   // Restoring square root, one result bit per cycle.
   always_comb begin
      trial   = root_ff + bit_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = radicand;
         root_in = '0;
         bit_in  = RAD_W'(1) << (RAD_W - 1);
         run_in  = 1'b1;
      end else if (run_ff) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff[ROOT_W-1:0];

   // A new root is only requested while the unit is free.
   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff)
      else $error("square root started while busy");

   // Every finished iteration run reports completion.
   a_done_on_end : assert property (@(posedge clock) disable iff (reset)
      $fell(run_ff) |-> done_ff)
      else $error("square root ended without done");

endmodule

// File: hdl/twre_back.sv
module twre_back import twre_pkg::*; #(
   parameter int MAX_CUSTOMERS = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  twre_cfg_type  cfg,
   input  logic          q_valid,
   input  twre_job_type  q_job,
   output logic          q_pop,
   twre_rsp_if.source    rsp_chan
);

   localparam int ADDR_W = $clog2(MAX_CUSTOMERS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_SQX,
      S_SQY,
      S_SUM,
      S_ROOT,
      S_ARRIVE,
      S_CHECK,
      S_REPLY
   } state_type;

   state_type             state_ff, state_in;
   logic                  finish_ff, finish_in;
   logic                  started_ff, started_in;
   twre_fail_type         status_ff, status_in;
   logic [LOAD_W-1:0]     load_ff, load_in;
   logic [CLOCK_W-1:0]    cost_ff, cost_in;
   logic [CLOCK_W-1:0]    elapsed_ff, elapsed_in;
   logic [COORD_W-1:0]    prev_x_ff, prev_x_in;
   logic [COORD_W-1:0]    prev_y_ff, prev_y_in;
   logic [COORD_W-1:0]    tgt_x_ff, tgt_x_in;
   logic [COORD_W-1:0]    tgt_y_ff, tgt_y_in;
   logic [TIME_W-1:0]     ready_ff, ready_in;
   logic [TIME_W-1:0]     due_ff, due_in;
   logic [TIME_W-1:0]     service_ff, service_in;
   logic [SQ_W-1:0]       sq_x_ff, sq_x_in;
   logic [SQ_W-1:0]       sq_y_ff, sq_y_in;
   logic [ROOT_W-1:0]     travel_ff, travel_in;
   logic [ARRIVE_W-1:0]   arrival_ff, arrival_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CLOCK_W-1:0]    rsp_cost_ff, rsp_cost_in;
   logic                  rsp_feasible_ff, rsp_feasible_in;
   logic [FAIL_W-1:0]     rsp_reason_ff, rsp_reason_in;

   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_addr;
   logic [ENTRY_W-1:0]    ram_rdata;
   twre_entry_type        rd_entry;
   logic                  sqrt_start;
   logic [RAD_W-1:0]      radicand;
   logic                  sqrt_done;
   logic [ROOT_W-1:0]     sqrt_root;

   logic [COORD_W-1:0]    prev_x_sel, prev_y_sel;
   logic [COORD_W-1:0]    dx, dy;
   logic [SQ_W:0]         sq_sum;
   logic [LOAD_W-1:0]     load_sum;
   logic [ARRIVE_W-1:0]   ready_q, due_q, start_q;
   logic [CLOCK_W-1:0]    return_cost;

   // Customer table: one entry per customer, written by loads and read by visits.
   twre_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_CUSTOMERS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_addr),
      .wdata (q_job.entry),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   twre_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign rd_entry = twre_entry_type'(ram_rdata);
   assign ram_addr = ADDR_W'(q_job.customer_index);
   assign q_pop    = (state_ff == S_IDLE) && q_valid;
   assign ram_we   = q_pop && (q_job.op == OP_LOAD);

   // Until the first visit the previous stop is the depot.
   assign prev_x_sel = started_ff ? prev_x_ff : cfg.depot_x;
   assign prev_y_sel = started_ff ? prev_y_ff : cfg.depot_y;
   assign dx = (prev_x_sel > tgt_x_ff) ? prev_x_sel - tgt_x_ff : tgt_x_ff - prev_x_sel;
   assign dy = (prev_y_sel > tgt_y_ff) ? prev_y_sel - tgt_y_ff : tgt_y_ff - prev_y_sel;

   // Squared distance in Q.8 becomes a Q.32 radicand.
   assign sq_sum     = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   assign radicand   = {sq_sum, {RAD_SHIFT{1'b0}}};
   assign sqrt_start = (state_ff == S_SUM);

   assign load_sum = load_ff + LOAD_W'(rd_entry.demand);

   // Time window arithmetic on Q32.16 values.
   assign ready_q = ARRIVE_W'({ready_ff, {FRAC_W{1'b0}}});
   assign due_q   = ARRIVE_W'({due_ff, {FRAC_W{1'b0}}});
   assign start_q = (ready_q > arrival_ff) ? ready_q : arrival_ff;

   assign return_cost = cost_ff + (started_ff ? CLOCK_W'(travel_ff) : '0);

   // Route sequencer.
   always_comb begin
      state_in        = state_ff;
      finish_in       = finish_ff;
      started_in      = started_ff;
      status_in       = status_ff;
      load_in         = load_ff;
      cost_in         = cost_ff;
      elapsed_in      = elapsed_ff;
      prev_x_in       = prev_x_ff;
      prev_y_in       = prev_y_ff;
      tgt_x_in        = tgt_x_ff;
      tgt_y_in        = tgt_y_ff;
      ready_in        = ready_ff;
      due_in          = due_ff;
      service_in      = service_ff;
      sq_x_in         = sq_x_ff;
      sq_y_in         = sq_y_ff;
      travel_in       = travel_ff;
      arrival_in      = arrival_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_cost_in     = rsp_cost_ff;
      rsp_feasible_in = rsp_feasible_ff;
      rsp_reason_in   = rsp_reason_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               case (q_job.op)
                  OP_VISIT: begin
                     if (status_ff == FAIL_NONE) begin
                        if (q_job.bad_index) begin
                           status_in = FAIL_INDEX;
                        end else begin
                           started_in = 1'b1;
                           prev_x_in  = prev_x_sel;
                           prev_y_in  = prev_y_sel;
                           finish_in  = 1'b0;
                           state_in   = S_READ;
                        end
                     end
                  end
                  OP_FINISH: begin
                     finish_in = 1'b1;
                     tgt_x_in  = cfg.depot_x;
                     tgt_y_in  = cfg.depot_y;
                     if (status_ff == FAIL_NONE && started_ff) begin
                        state_in = S_SQX;
                     end else begin
                        state_in = S_REPLY;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            load_in = load_sum;
            if (load_sum > LOAD_W'(cfg.vehicle_capacity)) begin
               status_in = FAIL_CAPACITY;
               state_in  = S_IDLE;
            end else begin
               tgt_x_in   = rd_entry.pos_x;
               tgt_y_in   = rd_entry.pos_y;
               ready_in   = rd_entry.open_time;
               due_in     = rd_entry.due_time;
               service_in = rd_entry.dwell_time;
               state_in   = S_SQX;
            end
         end
         S_SQX: begin
            sq_x_in  = SQ_W'(dx) * SQ_W'(dx);
            state_in = S_SQY;
         end
         S_SQY: begin
            sq_y_in  = SQ_W'(dy) * SQ_W'(dy);
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (sqrt_done) begin
               travel_in = sqrt_root;
               state_in  = finish_ff ? S_REPLY : S_ARRIVE;
            end
         end
         S_ARRIVE: begin
            arrival_in = ARRIVE_W'(elapsed_ff) + ARRIVE_W'(travel_ff);
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            if (start_q > due_q) begin
               status_in = FAIL_LATE;
            end else begin
               // Travel plus waiting equals the service start minus the old clock.
               cost_in    = cost_ff + CLOCK_W'(start_q - ARRIVE_W'(elapsed_ff));
               elapsed_in = CLOCK_W'(start_q + ARRIVE_W'({service_ff, {FRAC_W{1'b0}}}));
               prev_x_in  = tgt_x_ff;
               prev_y_in  = tgt_y_ff;
            end
            state_in = S_IDLE;
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_feasible_in = (status_ff == FAIL_NONE);
               rsp_reason_in   = status_ff;
               rsp_cost_in     = (status_ff == FAIL_NONE) ? return_cost : '0;
               started_in      = 1'b0;
               status_in       = FAIL_NONE;
               load_in         = '0;
               cost_in         = '0;
               elapsed_in      = '0;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      finish_ff       <= finish_in;
      prev_x_ff       <= prev_x_in;
      prev_y_ff       <= prev_y_in;
      tgt_x_ff        <= tgt_x_in;
      tgt_y_ff        <= tgt_y_in;
      ready_ff        <= ready_in;
      due_ff          <= due_in;
      service_ff      <= service_in;
      sq_x_ff         <= sq_x_in;
      sq_y_ff         <= sq_y_in;
      travel_ff       <= travel_in;
      arrival_ff      <= arrival_in;
      rsp_cost_ff     <= rsp_cost_in;
      rsp_feasible_ff <= rsp_feasible_in;
      rsp_reason_ff   <= rsp_reason_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         started_ff   <= 1'b0;
         status_ff    <= FAIL_NONE;
         load_ff      <= '0;
         cost_ff      <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         status_ff    <= status_in;
         load_ff      <= load_in;
         cost_ff      <= cost_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.route_cost  = rsp_cost_ff;
   assign rsp_chan.feasible    = rsp_feasible_ff;
   assign rsp_chan.fail_reason = rsp_reason_ff;

   // The first failure of a route holds until the route is reported.
   a_status_sticky : assert property (@(posedge clock) disable iff (reset)
      (status_ff != FAIL_NONE && state_ff != S_REPLY) |=> (status_ff == $past(status_ff)))
      else $error("route failure reason changed before finish");

   // A route without visits has spent no time and no cost.
   a_empty_route : assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (cost_ff == '0 && elapsed_ff == '0))
      else $error("cost or clock moved before the first visit");

endmodule

// File: hdl/time_window_route_evaluator.sv
// A load writes the customer table; a visit reads its table entry, squares both distances,
// sums them, runs a 29-step iterative square root, computes arrival and checks the window.
// A finish adds a return leg to a started, failure-free route; its result waits until taken.
// The back end takes a new transaction only once it is through with the last; a two-entry
// queue keeps accepting transactions meanwhile. Reset clears route state and restores
// the configuration defaults; the customer table is not cleared.
module time_window_route_evaluator import twre_pkg::*; #(
   parameter int MAX_CUSTOMERS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   twre_req_if.sink               req_chan,
   twre_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   twre_cfg_type cfg_ff, cfg_in;
   logic         push;
   twre_job_type push_job;
   logic         full;
   logic         q_valid;
   logic         q_pop;
   twre_job_type q_job;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DEPOT_X:  cfg_in.depot_x          = csr_wdata;
            CSR_DEPOT_Y:  cfg_in.depot_y          = csr_wdata;
            CSR_CAPACITY: cfg_in.vehicle_capacity = csr_wdata;
            CSR_COUNT:    cfg_in.customer_count   = csr_wdata[COUNT_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depot_x          <= '0;
         cfg_ff.depot_y          <= '0;
         cfg_ff.vehicle_capacity <= '1;
         cfg_ff.customer_count   <= COUNT_W'(256);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accepts and classifies transactions.
   twre_front #(
      .MAX_CUSTOMERS (MAX_CUSTOMERS)
   ) u_front (
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .push     (push),
      .push_job (push_job),
      .full     (full)
   );

   twre_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_job (q_job)
   );

   // Back end: table access, route arithmetic and result register.
   twre_back #(
      .MAX_CUSTOMERS (MAX_CUSTOMERS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_job    (q_job),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
